/* rtl/core/ceconv_pkg.sv */
// Shared types and constants for the clamped-edge convolution core.
`default_nettype none

package ceconv_pkg;

   // Fixed field widths
   localparam int COEF_BITS     = 16;
   localparam int CIDX_BITS     = 5;
   localparam int OUT_BITS      = 16;
   localparam int Y_BITS        = 16;
   localparam int CFG_BITS      = 16;
   localparam int CFG_ADDR_BITS = 3;
   localparam int R_BITS        = 2;
   localparam int WREG_BITS     = 11;

   // Command codes carried in tuser
   localparam logic CMD_COEF  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Configuration register indexes
   typedef enum logic [CFG_ADDR_BITS-1:0] {
      CSR_RADIUS  = 3'd0,
      CSR_WIDTH   = 3'd1,
      CSR_HEIGHT  = 3'd2,
      CSR_OUT_MIN = 3'd3,
      CSR_OUT_MAX = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_LOAD
   } state_type;

   // Coefficient write broadcast to the cell row
   typedef struct packed {
      logic                        we;
      logic [CIDX_BITS-1:0]        index;
      logic signed [COEF_BITS-1:0] value;
   } coef_wr_type;

endpackage

`default_nettype wire

/* rtl/core/clamped_edge_kernel_convolution_core.sv */
// Top level: 2-D convolution with replicated border and saturated output.
//
// Items arrive on the req_ stream: tuser 0 loads one kernel coefficient,
// tuser 1 delivers the next pixel of the raster in row order. Results leave
// on the rsp_ stream; tlast marks the final result caused by one pixel.
// Geometry and bounds are set through the csr_ write port while idle; the
// user must keep to this, the block does not enforce it. Writing radius,
// width or height restarts the frame at pixel (0,0). A coefficient load or
// a pixel that completes no window leaves the block idle. For each result
// the window is read one pixel per cycle from the line store and its partial
// sum rides down a chain of multiply-accumulate cells, one cell per kernel
// tap. A pixel at the end of a row or frame gives up to (r+1)^2 results back
// to back. New items are refused while results of an earlier pixel are being
// made. The output register holds a result until rsp_tready; the chain waits
// for it. Reset clears the counters and registers (radius 1, width 1024,
// height 1, full 16-bit bounds); coefficients and line store start unset.
`default_nettype none

module clamped_edge_kernel_convolution_core
   import ceconv_pkg::*;
#(
   parameter int MAX_KERNEL = 5,
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16,
   localparam int IN_BITS   = CIDX_BITS + COEF_BITS + PIXEL_BITS,
   localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8,
   localparam int X_BITS    = $clog2(MAX_WIDTH),
   localparam int OUT_FLDS  = X_BITS + Y_BITS + OUT_BITS,
   localparam int OUT_TDATA = ((OUT_FLDS + 7) / 8) * 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire [IN_TDATA-1:0]       req_tdata,   // coef_index, coef_value, pixel
   input  wire                      req_tuser,   // cmd
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [OUT_TDATA-1:0]     rsp_tdata,   // out_x, out_y, value
   output logic                     rsp_tlast,   // last
   input  wire                      csr_we,
   input  wire [CFG_ADDR_BITS-1:0]  csr_index,
   input  wire [CFG_BITS-1:0]       csr_wdata
);

   localparam int MAX_RADIUS = (MAX_KERNEL - 1) / 2;
   localparam int TAPS       = MAX_KERNEL * MAX_KERNEL;
   localparam int TAP_BITS   = $clog2(TAPS);
   localparam int K_BITS     = $clog2(MAX_KERNEL + 1);
   localparam int W_BITS     = X_BITS + 1;
   localparam int SLOT_BITS  = $clog2(MAX_KERNEL);
   localparam int DEPTH      = MAX_KERNEL * MAX_WIDTH;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int ACC_BITS   = PIXEL_BITS + COEF_BITS + TAP_BITS;
   localparam logic signed [SLOT_BITS+1:0] MK_S = (SLOT_BITS+2)'(MAX_KERNEL);

   // Configuration registers
   logic [R_BITS-1:0]           radius_ff;
   logic [WREG_BITS-1:0]        width_ff;
   logic [CFG_BITS-1:0]         height_ff;
   logic signed [OUT_BITS-1:0]  out_min_ff;
   logic signed [OUT_BITS-1:0]  out_max_ff;

   // Effective geometry
   logic [R_BITS-1:0]  r_eff;
   logic [W_BITS-1:0]  w_eff;
   logic [Y_BITS-1:0]  h_eff;
   logic [K_BITS-1:0]  side;
   logic [TAP_BITS-1:0] fin_idx;

   // Input fields
   logic                         cmd;
   logic [CIDX_BITS-1:0]         coef_index;
   logic signed [COEF_BITS-1:0]  coef_value;
   logic signed [PIXEL_BITS-1:0] pixel;
   logic                         req_fire;
   logic                         pix_fire;
   coef_wr_type                  coef_wr;

   // Raster position
   logic [X_BITS-1:0]    col_ff;
   logic [Y_BITS-1:0]    row_ff;
   logic [SLOT_BITS-1:0] rslot_ff;
   logic                 col_last;
   logic                 row_last;
   logic                 geo_write;

   // Result span of the current pixel
   logic                 x_has;
   logic                 y_has;
   logic [X_BITS-1:0]    x0;
   logic [X_BITS-1:0]    x1;
   logic [Y_BITS-1:0]    y0;
   logic [Y_BITS-1:0]    y1;
   logic [R_BITS-1:0]    dy0;
   logic [SLOT_BITS-1:0] ys0;

   // Result walk registers
   logic [X_BITS-1:0]    x_ff;
   logic [X_BITS-1:0]    x_lo_ff;
   logic [X_BITS-1:0]    x_hi_ff;
   logic [Y_BITS-1:0]    y_ff;
   logic [Y_BITS-1:0]    y_hi_ff;
   logic [SLOT_BITS-1:0] ys_ff;
   logic [K_BITS-1:0]    ky_ff;
   logic [K_BITS-1:0]    kx_ff;
   logic                 res_last;

   // Sequencer
   state_type state_ff;
   state_type state_in;
   logic      issue;
   logic      tap_end;
   logic      capture;
   logic      load;

   // Line store access
   logic signed [PIXEL_BITS-1:0] line_mem [DEPTH];
   logic [ADDR_BITS-1:0]         wr_addr;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic signed [PIXEL_BITS-1:0] rd_data_ff;
   logic                         rd_first_ff;
   logic [Y_BITS:0]              ty;
   logic [Y_BITS:0]              sy;
   logic signed [3:0]            dy;
   logic signed [SLOT_BITS+1:0]  st;
   logic [SLOT_BITS-1:0]         slot;
   logic [W_BITS:0]              tx;
   logic [W_BITS:0]              sxw;
   logic [X_BITS-1:0]            sx;

   // Cell chain
   logic                       cell_valid [TAPS];
   logic signed [ACC_BITS-1:0] cell_sum [TAPS];
   logic signed [ACC_BITS-1:0] sum_hold_ff;

   // Output stage
   logic signed [ACC_BITS-1:0] sat_lo;
   logic signed [ACC_BITS-1:0] sat_hi;
   logic signed [ACC_BITS-1:0] sat_v;
   logic                       rsp_valid_ff;
   logic [X_BITS-1:0]          rsp_x_ff;
   logic [Y_BITS-1:0]          rsp_y_ff;
   logic [OUT_BITS-1:0]        rsp_val_ff;
   logic                       rsp_last_ff;

   // Unpack the request
   assign cmd        = req_tuser;
   assign coef_index = req_tdata[CIDX_BITS-1:0];
   assign coef_value = req_tdata[CIDX_BITS+COEF_BITS-1:CIDX_BITS];
   assign pixel      = req_tdata[IN_BITS-1:CIDX_BITS+COEF_BITS];
   assign req_fire   = req_tvalid && req_tready;
   assign pix_fire   = req_fire && (cmd == CMD_PIXEL);

   assign coef_wr.we    = req_fire && (cmd == CMD_COEF);
   assign coef_wr.index = coef_index;
   assign coef_wr.value = coef_value;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= R_BITS'(1);
         width_ff   <= WREG_BITS'(1024);
         height_ff  <= CFG_BITS'(1);
         out_min_ff <= 16'sh8000;
         out_max_ff <= 16'sh7fff;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:  radius_ff  <= csr_wdata[R_BITS-1:0];
            CSR_WIDTH:   width_ff   <= csr_wdata[WREG_BITS-1:0];
            CSR_HEIGHT:  height_ff  <= csr_wdata;
            CSR_OUT_MIN: out_min_ff <= csr_wdata;
            CSR_OUT_MAX: out_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign geo_write = csr_we &&
      ((csr_index == CSR_RADIUS) || (csr_index == CSR_WIDTH) || (csr_index == CSR_HEIGHT));

   // Saturate geometry into the supported range
   always_comb begin
      if (radius_ff == '0) begin
         r_eff = R_BITS'(1);
      end else if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = R_BITS'(MAX_RADIUS);
      end else begin
         r_eff = radius_ff;
      end
      if (width_ff == '0) begin
         w_eff = W_BITS'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = W_BITS'(MAX_WIDTH);
      end else begin
         w_eff = W_BITS'(width_ff);
      end
      h_eff = (height_ff == '0) ? Y_BITS'(1) : height_ff;
   end

   assign side    = K_BITS'({r_eff, 1'b1});
   assign fin_idx = TAP_BITS'(int'(side) * int'(side) - 1);

   // Result span of the incoming pixel
   always_comb begin
      col_last = (W_BITS'(col_ff) + W_BITS'(1)) >= w_eff;
      row_last = ({1'b0, row_ff} + (Y_BITS+1)'(1)) >= {1'b0, h_eff};
      x_has    = col_last || (col_ff >= X_BITS'(r_eff));
      y_has    = row_last || (row_ff >= Y_BITS'(r_eff));
      x0 = (col_ff >= X_BITS'(r_eff)) ? col_ff - X_BITS'(r_eff) : '0;
      y0 = (row_ff >= Y_BITS'(r_eff)) ? row_ff - Y_BITS'(r_eff) : '0;
      x1 = col_last ? X_BITS'(w_eff - W_BITS'(1)) : x0;
      y1 = row_last ? h_eff - Y_BITS'(1) : y0;
      dy0 = R_BITS'(row_ff - y0);
      if (rslot_ff >= SLOT_BITS'(dy0)) begin
         ys0 = rslot_ff - SLOT_BITS'(dy0);
      end else begin
         ys0 = SLOT_BITS'(MAX_KERNEL) + rslot_ff - SLOT_BITS'(dy0);
      end
   end

   // Advance the raster position
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         rslot_ff <= '0;
      end else if (geo_write) begin
         col_ff   <= '0;
         row_ff   <= '0;
         rslot_ff <= '0;
      end else if (pix_fire) begin
         if (col_last) begin
            col_ff <= '0;
            if (row_last) begin
               row_ff   <= '0;
               rslot_ff <= '0;
            end else begin
               row_ff   <= row_ff + Y_BITS'(1);
               rslot_ff <= (rslot_ff == SLOT_BITS'(MAX_KERNEL - 1)) ?
                           '0 : rslot_ff + SLOT_BITS'(1);
            end
         end else begin
            col_ff <= col_ff + X_BITS'(1);
         end
      end
   end

   // Next state
   assign tap_end  = (kx_ff == side - K_BITS'(1)) && (ky_ff == side - K_BITS'(1));
   assign res_last = (x_ff == x_hi_ff) && (y_ff == y_hi_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pix_fire && x_has && y_has) state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (tap_end) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (cell_valid[fin_idx]) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = res_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      capture    = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ISSUE: issue      = 1'b1;
         ST_WAIT:  capture    = cell_valid[fin_idx];
         ST_LOAD:  load       = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Walk results and window taps
   always_ff @(posedge clock) begin
      if (pix_fire) begin
         x_ff    <= x0;
         x_lo_ff <= x0;
         x_hi_ff <= x1;
         y_ff    <= y0;
         y_hi_ff <= y1;
         ys_ff   <= ys0;
         ky_ff   <= '0;
         kx_ff   <= '0;
      end else if (issue) begin
         if (kx_ff == side - K_BITS'(1)) begin
            kx_ff <= '0;
            ky_ff <= ky_ff + K_BITS'(1);
         end else begin
            kx_ff <= kx_ff + K_BITS'(1);
         end
      end else if (load && !res_last) begin
         ky_ff <= '0;
         kx_ff <= '0;
         if (x_ff == x_hi_ff) begin
            x_ff  <= x_lo_ff;
            y_ff  <= y_ff + Y_BITS'(1);
            ys_ff <= (ys_ff == SLOT_BITS'(MAX_KERNEL - 1)) ? '0 : ys_ff + SLOT_BITS'(1);
         end else begin
            x_ff <= x_ff + X_BITS'(1);
         end
      end
   end

   // Tap address with edge replication
   always_comb begin
      ty = {1'b0, y_ff} + (Y_BITS+1)'(ky_ff);
      if (ty < (Y_BITS+1)'(r_eff)) begin
         sy = '0;
      end else begin
         sy = ty - (Y_BITS+1)'(r_eff);
      end
      if (sy > ({1'b0, h_eff} - (Y_BITS+1)'(1))) begin
         sy = {1'b0, h_eff} - (Y_BITS+1)'(1);
      end
      dy = 4'(sy - {1'b0, y_ff});
      st = (SLOT_BITS+2)'({2'b00, ys_ff}) + (SLOT_BITS+2)'(dy);
      if (st < 0) begin
         st = st + MK_S;
      end else if (st >= MK_S) begin
         st = st - MK_S;
      end
      slot = SLOT_BITS'(st);
      tx = (W_BITS+1)'(x_ff) + (W_BITS+1)'(kx_ff);
      if (tx < (W_BITS+1)'(r_eff)) begin
         sxw = '0;
      end else begin
         sxw = tx - (W_BITS+1)'(r_eff);
      end
      if (sxw > ((W_BITS+1)'(w_eff) - (W_BITS+1)'(1))) begin
         sxw = (W_BITS+1)'(w_eff) - (W_BITS+1)'(1);
      end
      sx = X_BITS'(sxw);
   end

   assign rd_addr = ADDR_BITS'(slot) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(sx);
   assign wr_addr = ADDR_BITS'(rslot_ff) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(col_ff);

   // Line store: last MAX_KERNEL rows, one slot per row
   always_ff @(posedge clock) begin
      if (pix_fire) begin
         line_mem[wr_addr] <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= line_mem[rd_addr];
   end

   // Mark the first tap of a window entering the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_first_ff <= 1'b0;
      end else begin
         rd_first_ff <= issue && (ky_ff == '0) && (kx_ff == '0);
      end
   end

   // Tap chain
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      if (k == 0) begin : g_head
         ceconv_cell #(
            .INDEX      (k),
            .PIXEL_BITS (PIXEL_BITS),
            .ACC_BITS   (ACC_BITS)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .coef_wr        (coef_wr),
            .pixel          (rd_data_ff),
            .link_valid_in  (rd_first_ff),
            .link_sum_in    ('0),
            .link_valid_out (cell_valid[k]),
            .link_sum_out   (cell_sum[k])
         );
      end else begin : g_body
         ceconv_cell #(
            .INDEX      (k),
            .PIXEL_BITS (PIXEL_BITS),
            .ACC_BITS   (ACC_BITS)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .coef_wr        (coef_wr),
            .pixel          (rd_data_ff),
            .link_valid_in  (cell_valid[k-1]),
            .link_sum_in    (cell_sum[k-1]),
            .link_valid_out (cell_valid[k]),
            .link_sum_out   (cell_sum[k])
         );
      end
   end

   // Hold the finished window sum
   always_ff @(posedge clock) begin
      if (capture) begin
         sum_hold_ff <= cell_sum[fin_idx];
      end
   end

   // Saturate: raise to out_min, then lower to out_max
   always_comb begin
      sat_lo = ACC_BITS'(out_min_ff);
      sat_hi = ACC_BITS'(out_max_ff);
      sat_v  = (sum_hold_ff < sat_lo) ? sat_lo : sum_hold_ff;
      if (sat_v > sat_hi) begin
         sat_v = sat_hi;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_x_ff    <= x_ff;
         rsp_y_ff    <= y_ff;
         rsp_val_ff  <= OUT_BITS'(sat_v);
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_TDATA'({rsp_val_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/core/ceconv_cell.sv */
// One multiply-accumulate cell of the kernel tap chain.
`default_nettype none

module ceconv_cell
   import ceconv_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int PIXEL_BITS = 16,
   parameter int ACC_BITS   = 37
) (
   input  wire                         clock,
   input  wire                         reset,
   input  coef_wr_type                 coef_wr,
   input  wire signed [PIXEL_BITS-1:0] pixel,
   input  wire                         link_valid_in,
   input  wire signed [ACC_BITS-1:0]   link_sum_in,
   output logic                        link_valid_out,
   output logic signed [ACC_BITS-1:0]  link_sum_out
);

   logic signed [COEF_BITS-1:0]            coef_ff;
   logic signed [PIXEL_BITS+COEF_BITS-1:0] prod;
   logic signed [ACC_BITS-1:0]             sum_in;
   logic                                   valid_ff;
   logic signed [ACC_BITS-1:0]             sum_ff;

   // Hold this tap's coefficient
   always_ff @(posedge clock) begin
      if (coef_wr.we && (int'(coef_wr.index) == INDEX)) begin
         coef_ff <= coef_wr.value;
      end
   end

   // Add this tap's product to the partial sum from the left neighbor
   assign prod   = pixel * coef_ff;
   assign sum_in = link_sum_in + ACC_BITS'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= link_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign link_valid_out = valid_ff;
   assign link_sum_out   = sum_ff;

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the clamped-edge convolution core.
`timescale 1ns / 1ps

module tb;
   import ceconv_pkg::*;

   typedef struct packed {
      logic [9:0]         x;
      logic [15:0]        y;
      logic signed [15:0] v;
      logic               last;
   } conv_result_type;

   // Predicts convolution results and matches them against the block's output
   class conv_scoreboard;
      conv_result_type    pending_pixels[$];
      logic signed [15:0] lines[0:5119];
      logic signed [15:0] taps[0:24];
      int radius, width, height, col, row, lo_bound, hi_bound;
      int errors, results;

      function new();
         radius = 1; width = 1024; height = 1;
         lo_bound = -32768; hi_bound = 32767;
         col = 0; row = 0; errors = 0; results = 0;
         foreach (lines[i]) lines[i] = '0;
         foreach (taps[i]) taps[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] d);
         case (idx)
            CSR_RADIUS: begin
               radius = d[1:0]; col = 0; row = 0;
            end
            CSR_WIDTH: begin
               width = d[10:0]; col = 0; row = 0;
            end
            CSR_HEIGHT: begin
               height = d; col = 0; row = 0;
            end
            CSR_OUT_MIN: lo_bound = $signed(d);
            CSR_OUT_MAX: hi_bound = $signed(d);
            default: ;
         endcase
      endfunction

      // Coordinates whose lower-right window pixel sits at position p
      function bit span(int p, int rr, int n, output int lo, output int hi);
         lo = 0; hi = 0;
         if (p + 1 < n) begin
            if (p < rr) return 0;
            lo = p - rr; hi = lo;
            return 1;
         end
         lo = (p >= rr) ? p - rr : 0;
         hi = n - 1;
         return 1;
      endfunction

      function longint window_sum(int x, int y, int rr, int w, int h);
         int side, sy, sx;
         longint acc;
         side = 2 * rr + 1;
         acc = 0;
         for (int ky = 0; ky < side; ky++) begin
            sy = y + ky - rr;
            if (sy < 0) sy = 0;
            if (sy > h - 1) sy = h - 1;
            for (int kx = 0; kx < side; kx++) begin
               sx = x + kx - rr;
               if (sx < 0) sx = 0;
               if (sx > w - 1) sx = w - 1;
               acc += longint'(taps[ky * side + kx]) * longint'(lines[(sy % 5) * 1024 + sx]);
            end
         end
         // raise to the floor first, so the ceiling wins when they cross
         if (acc < lo_bound) acc = lo_bound;
         if (acc > hi_bound) acc = hi_bound;
         return acc;
      endfunction

      function void convolve_item(logic cmd, logic [4:0] idx, logic signed [15:0] cv,
                                  logic signed [15:0] px);
         int rr, w, h, x0, x1, y0, y1, n;
         conv_result_type res;
         if (cmd == CMD_COEF) begin
            if (idx < 25) taps[idx] = cv;
            return;
         end
         rr = (radius < 1) ? 1 : (radius > 2) ? 2 : radius;
         w = (width < 1) ? 1 : (width > 1024) ? 1024 : width;
         h = (height < 1) ? 1 : height;
         lines[(row % 5) * 1024 + col] = px;
         n = 0;
         if (span(row, rr, h, y0, y1) && span(col, rr, w, x0, x1)) begin
            for (int y = y0; y <= y1; y++) begin
               for (int x = x0; x <= x1; x++) begin
                  res.x = 10'(x); res.y = 16'(y);
                  res.v = 16'(window_sum(x, y, rr, w, h));
                  res.last = 1'b0;
                  pending_pixels.push_back(res);
                  n++;
               end
            end
            if (n > 0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
         end
         col++;
         if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
         end
      endfunction

      function void check_result(logic [9:0] x, logic [15:0] y, logic signed [15:0] v,
                                 logic last);
         conv_result_type e;
         results++;
         if (pending_pixels.size() == 0) begin
            $error("unexpected result x=%0d y=%0d value=%0d", x, y, v);
            errors++;
            return;
         end
         e = pending_pixels.pop_front();
         if (x !== e.x) begin
            $error("out_x expected %0d got %0d", e.x, x); errors++;
         end
         if (y !== e.y) begin
            $error("out_y expected %0d got %0d", e.y, y); errors++;
         end
         if (v !== e.v) begin
            $error("value expected %0d got %0d", e.v, v); errors++;
         end
         if (last !== e.last) begin
            $error("last expected %0d got %0d", e.last, last); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   conv_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;
   int items = 0;
   int rand_items = 0;
   int settings = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   clamped_edge_kernel_convolution_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Drive the result-side ready; one long hold-off on request
   int  hold_left = 0;
   bit  hold_taken = 1'b0;
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check each result transfer and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[9:0], rsp_tdata[25:10], rsp_tdata[41:26], rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= 3000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_item(logic cmd, logic [4:0] idx, logic [15:0] cv, logic [15:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b000, px, cv, idx};
      do @(posedge clock); while (!req_tready);
      sb.convolve_item(cmd, idx, cv, px);
      items++;
   endtask

   task automatic send_pixel(logic [15:0] px);
      send_item(CMD_PIXEL, 5'($urandom), 16'($urandom), px);
   endtask

   task automatic send_coef(logic [4:0] idx, logic [15:0] cv);
      send_item(CMD_COEF, idx, cv, 16'($urandom));
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   // Hold until every predicted result has been transferred
   task automatic drain();
      while (sb.pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Drain, let the block settle, then load a full register set
   task automatic configure(int rr, int w, int h, int lo, int hi);
      req_tvalid <= 1'b0;
      drain();
      @(posedge clock);
      repeat (40) @(posedge clock);
      write_csr(CSR_RADIUS, 16'(rr));
      write_csr(CSR_WIDTH, 16'(w));
      write_csr(CSR_HEIGHT, 16'(h));
      write_csr(CSR_OUT_MIN, 16'(lo));
      write_csr(CSR_OUT_MAX, 16'(hi));
      csr_we <= 1'b0;
      settings++;
   endtask

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(7));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int w, h, lo, hi;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme coefficients, ignored indexes, corner geometries
      configure(1, 3, 2, -32768, 32767);
      for (int i = 0; i < 25; i++)
         send_coef(5'(i),
                   (i == 0) ? 16'h8000 : (i == 4) ? 16'h7fff :
                   16'($urandom_range(40)) - 16'd20);
      send_coef(5'd31, 16'h1234);
      send_coef(5'd25, 16'hffff);
      send_pixel(16'h8000); send_pixel(16'h7fff); send_pixel(16'h0000);
      send_pixel(16'hffff); send_pixel(16'h0001); send_pixel(16'h8000);
      // crossed bounds, radius zero raised to one, single pixel frame
      configure(0, 1, 1, 100, -100);
      send_pixel(16'h7fff);
      // radius three lowered to two, width and height zero act as one
      configure(3, 0, 0, -32768, 32767);
      send_pixel(16'h1234);
      // widest row, with an over-range width, cut short mid-frame
      configure(1, 2047, 1, -5, 5);
      send_pixel(16'h0f0f); send_pixel(16'hf0f0); send_pixel(16'h5555);
      configure(2, 1024, 1, -32768, 32767);
      send_pixel(16'h2222); send_pixel(16'h3333); send_pixel(16'hcccc);
      // tallest frame, only the first rows
      configure(2, 2, 65535, -32768, 32767);
      for (int i = 0; i < 6; i++) send_pixel(rand_pixel());

      // Random frames under changing settings and traffic
      for (int phase = 0; items < 330; phase++) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 5);
         case ($urandom_range(2))
            0: begin lo = -32768; hi = 32767; end
            1: begin
               lo = $urandom_range(0, 4000) - 4000;
               hi = $urandom_range(0, 4000);
            end
            default: begin
               lo = int'($signed(16'($urandom)));
               hi = int'($signed(16'($urandom)));
            end
         endcase
         configure($urandom_range(1, 2), w, h, lo, hi);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         if (phase == 2) begin
            send_idle_pct = 0;
            hold_request = 1'b1;
         end
         repeat ($urandom_range(1, 2)) begin
            for (int p = 0; p < w * h; p++) begin
               if ($urandom_range(9) == 0) begin
                  send_coef(5'($urandom), 16'($urandom));
                  rand_items++;
               end
               send_pixel(rand_pixel());
               rand_items++;
            end
         end
      end

      req_tvalid <= 1'b0;
      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d items (%0d random) over %0d register settings.",
               items, rand_items, settings);
      $display("Checked %0d results under mixed idle, stall and hold-off traffic.",
               sb.results);
      if (sb.errors == 0 && sb.pending_pixels.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
